// ===== hdl/qpg_pkg.sv =====
// ----------------------------------------------------------------------------
// qpg_pkg
// Shared types and constants of the quad panel geometry unit.
// ----------------------------------------------------------------------------
package qpg_pkg;

   typedef enum logic [2:0] {
      KIND_NORMAL = 3'd0,
      KIND_CHORD  = 3'd1,
      KIND_SPAN   = 3'd2,
      KIND_CTRL   = 3'd3,
      KIND_AREA   = 3'd4
   } kind_type;

   localparam int FRAC_BITS = 16;
   localparam int UNIT_BITS = 31;
   localparam int NORM_ROOT = 32;
   localparam int QUO_BITS  = 18;
   localparam int MAX_BITS  = 62;
   localparam int AREA_SHIFT = 17;

   typedef struct packed {
      logic                                zero;
      logic [2:0]                          neg;
      logic [2:0][UNIT_BITS-1:0]           mg;
   } norm_tag_type;

endpackage

// ===== hdl/qpg_sqrt.sv =====
// ----------------------------------------------------------------------------
// qpg_sqrt
// Pipelined integer square root, one root bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module qpg_sqrt #(
   parameter int VW = 64,
   parameter int RB = 32,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [VW-1:0] rad_in,
   input  logic [TW-1:0] tag_in,
   output logic [RB-1:0] root_out,
   output logic [TW-1:0] tag_out
);

   logic [2*RB-1:0] rad_ff  [RB];
   logic [RB+1:0]   rem_ff  [RB];
   logic [RB-1:0]   root_ff [RB];
   logic [TW-1:0]   tag_ff  [RB];

   for (genvar s = 0; s < RB; s++) begin : g_stage
      logic [2*RB-1:0] prad;
      logic [RB+1:0]   prem;
      logic [RB-1:0]   proot;
      logic [TW-1:0]   ptag;
      logic [RB+1:0]   cur_in;
      logic [RB+1:0]   trial;

      if (s == 0) begin : g_first
         assign prad  = (2*RB)'(rad_in);
         assign prem  = '0;
         assign proot = '0;
         assign ptag  = tag_in;
      end else begin : g_next
         assign prad  = rad_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign ptag  = tag_ff[s-1];
      end

      assign cur_in = {prem[RB-1:0], prad[2*RB-1:2*RB-2]};
      assign trial  = {proot, 2'b01};

      always_ff @(posedge clock) begin
         if (adv) begin
            if (cur_in >= trial) begin
               rem_ff[s]  <= cur_in - trial;
               root_ff[s] <= {proot[RB-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= cur_in;
               root_ff[s] <= {proot[RB-2:0], 1'b0};
            end
            rad_ff[s] <= prad << 2;
            tag_ff[s] <= ptag;
         end
      end
   end

   assign root_out = root_ff[RB-1];
   assign tag_out  = tag_ff[RB-1];

endmodule

// ===== hdl/qpg_norm.sv =====
// ----------------------------------------------------------------------------
// qpg_norm
// Pipelined unit vector: scale to 31 bits, root of the sum of squares,
// rounded restoring divide per component, clamp to the output range.
// ----------------------------------------------------------------------------
module qpg_norm #(
   parameter int IW  = 34,
   parameter int CW  = 32,
   parameter int PAD = 0
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [IW-1:0] vec_in   [3],
   output logic signed [CW-1:0] unit_out [3]
);
   import qpg_pkg::*;

   localparam int MW    = $clog2(IW + 1);
   localparam int SHW   = IW + UNIT_BITS;
   localparam int CMP_W = NORM_ROOT + QUO_BITS;
   localparam int XQ    = ((CW > QUO_BITS) ? CW : QUO_BITS) + 1;
   localparam logic signed [XQ-1:0] QHI = $signed({{(XQ-CW+1){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [XQ-1:0] QLO = -QHI - XQ'(1);
   localparam int TGW   = $bits(norm_tag_type);

   logic [IW-1:0]          mag1_ff [3];
   logic [2:0]             neg1_ff;
   logic [MW-1:0]          m1_ff;
   logic [IW-1:0]          mag_in  [3];
   logic [MW-1:0]          m_in;

   logic [UNIT_BITS-1:0]   mg2_ff [3];
   logic [UNIT_BITS-1:0]   mg_in  [3];
   logic [2:0]             neg2_ff;
   logic                   zero2_ff;

   logic [2*UNIT_BITS-1:0] sq3_ff [3];
   logic [UNIT_BITS-1:0]   mg3_ff [3];
   logic [2:0]             neg3_ff;
   logic                   zero3_ff;

   logic [63:0]            sum4_ff;
   norm_tag_type           tag4_ff;

   logic [NORM_ROOT-1:0]   root;
   logic [TGW-1:0]         tag_raw;
   norm_tag_type           tag_q;

   logic [CMP_W-1:0]       rem_ff  [QUO_BITS][3];
   logic [QUO_BITS-1:0]    quo_ff  [QUO_BITS][3];
   logic [NORM_ROOT-1:0]   den_ff  [QUO_BITS];
   logic [2:0]             negd_ff [QUO_BITS];
   logic                   zerod_ff[QUO_BITS];

   logic signed [CW-1:0]   uo_ff [3];

   always_comb begin
      logic [IW-1:0] orv;
      orv  = '0;
      m_in = '0;
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = vec_in[k][IW-1] ? IW'(-vec_in[k]) : IW'(vec_in[k]);
         orv = orv | mag_in[k];
      end
      for (int b = 0; b < IW; b++) begin
         if (orv[b]) begin
            m_in = MW'(b + 1);
         end
      end
   end

   always_comb begin
      logic [SHW-1:0] t;
      for (int k = 0; k < 3; k++) begin
         if (int'(m1_ff) > UNIT_BITS) begin
            t = SHW'(mag1_ff[k]) >> (int'(m1_ff) - UNIT_BITS);
         end else begin
            t = SHW'(mag1_ff[k]) << (UNIT_BITS - int'(m1_ff));
         end
         mg_in[k] = t[UNIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            mag1_ff[k] <= mag_in[k];
            neg1_ff[k] <= vec_in[k][IW-1];
            mg2_ff[k]  <= mg_in[k];
            sq3_ff[k]  <= (2*UNIT_BITS)'(mg2_ff[k]) * (2*UNIT_BITS)'(mg2_ff[k]);
            mg3_ff[k]  <= mg2_ff[k];
            tag4_ff.mg[k] <= mg3_ff[k];
         end
         m1_ff    <= m_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= (m1_ff == '0);
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         sum4_ff  <= 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
         tag4_ff.neg  <= neg3_ff;
         tag4_ff.zero <= zero3_ff;
      end
   end

   qpg_sqrt #(.VW(64), .RB(NORM_ROOT), .TW(TGW)) u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .rad_in   (sum4_ff),
      .tag_in   (tag4_ff),
      .root_out (root),
      .tag_out  (tag_raw)
   );

   assign tag_q = norm_tag_type'(tag_raw);

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
      localparam int B = QUO_BITS - 1 - s;
      logic [CMP_W-1:0]    prem [3];
      logic [QUO_BITS-1:0] pquo [3];
      logic [NORM_ROOT-1:0] pden;
      logic [2:0]          pneg;
      logic                pzero;
      logic [CMP_W-1:0]    dsh;

      if (s == 0) begin : g_first
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign prem[k] = (CMP_W'(tag_q.mg[k]) << FRAC_BITS) + CMP_W'(root >> 1);
            assign pquo[k] = '0;
         end
         assign pden  = root;
         assign pneg  = tag_q.neg;
         assign pzero = tag_q.zero;
      end else begin : g_next
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign prem[k] = rem_ff[s-1][k];
            assign pquo[k] = quo_ff[s-1][k];
         end
         assign pden  = den_ff[s-1];
         assign pneg  = negd_ff[s-1];
         assign pzero = zerod_ff[s-1];
      end

      assign dsh = CMP_W'(pden) << B;

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 3; k++) begin
               if (prem[k] >= dsh) begin
                  rem_ff[s][k]    <= prem[k] - dsh;
                  quo_ff[s][k]    <= pquo[k] | (QUO_BITS'(1) << B);
               end else begin
                  rem_ff[s][k]    <= prem[k];
                  quo_ff[s][k]    <= pquo[k];
               end
            end
            den_ff[s]   <= pden;
            negd_ff[s]  <= pneg;
            zerod_ff[s] <= pzero;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [XQ-1:0] sv;
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sv = $signed(XQ'(quo_ff[QUO_BITS-1][k]));
            if (negd_ff[QUO_BITS-1][k]) begin
               sv = -sv;
            end
            if (zerod_ff[QUO_BITS-1]) begin
               uo_ff[k] <= '0;
            end else if (sv > QHI) begin
               uo_ff[k] <= CW'(QHI);
            end else if (sv < QLO) begin
               uo_ff[k] <= CW'(QLO);
            end else begin
               uo_ff[k] <= CW'(sv);
            end
         end
      end
   end

   if (PAD > 0) begin : g_pad
      logic signed [CW-1:0] pad_ff [PAD][3];
      always_ff @(posedge clock) begin
         if (adv) begin
            pad_ff[0] <= uo_ff;
            for (int s = 1; s < PAD; s++) begin
               pad_ff[s] <= pad_ff[s-1];
            end
         end
      end
      assign unit_out = pad_ff[PAD-1];
   end else begin : g_nopad
      assign unit_out = uo_ff;
   end

endmodule

// ===== hdl/quad_panel_geometry_unit.sv =====
// ----------------------------------------------------------------------------
// quad_panel_geometry_unit
// Geometry of one quadrilateral panel: unit normal, chordwise and spanwise
// tangents, control point and area, five result transactions per panel.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    four corners, x y z each
//   rsp      out        rsp_valid/stall    kind, value x y z, last flag
//
// One panel enters per cycle while the pipeline is free; the result port
// delivers five transactions per panel, so the sustained panel rate is set
// by the single output port, which may still deliver one panel as new ones enter.
// The bitwise root and divide stages set the latency from acceptance to
// the first result. Reset clears the valid bits and the output buffer's
// busy flag and kind counter only.
// A stall freezes the whole pipeline only when its last stage holds a panel
// that the output buffer cannot take; an empty last stage never stalls it.
// ----------------------------------------------------------------------------
module quad_panel_geometry_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_lead_inner_x,
   input  logic signed [COORD_WIDTH-1:0] req_lead_inner_y,
   input  logic signed [COORD_WIDTH-1:0] req_lead_inner_z,
   input  logic signed [COORD_WIDTH-1:0] req_lead_outer_x,
   input  logic signed [COORD_WIDTH-1:0] req_lead_outer_y,
   input  logic signed [COORD_WIDTH-1:0] req_lead_outer_z,
   input  logic signed [COORD_WIDTH-1:0] req_trail_outer_x,
   input  logic signed [COORD_WIDTH-1:0] req_trail_outer_y,
   input  logic signed [COORD_WIDTH-1:0] req_trail_outer_z,
   input  logic signed [COORD_WIDTH-1:0] req_trail_inner_x,
   input  logic signed [COORD_WIDTH-1:0] req_trail_inner_y,
   input  logic signed [COORD_WIDTH-1:0] req_trail_inner_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_result_kind,
   output logic signed [COORD_WIDTH-1:0] rsp_value_x,
   output logic signed [COORD_WIDTH-1:0] rsp_value_y,
   output logic signed [COORD_WIDTH-1:0] rsp_value_z,
   output logic                          rsp_last_of_panel
);
   import qpg_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int KM   = (DW > MAX_BITS) ? DW - MAX_BITS : 0;
   localparam int EW   = (DW > MAX_BITS) ? MAX_BITS : DW;
   localparam int PW   = 2*EW + 2;
   localparam int XW   = PW + 1;
   localparam int SW   = 2*EW + 2;
   localparam int NORM_BASE = 4 + NORM_ROOT + QUO_BITS + 1;
   localparam int RB_E = (EW + 1 > NORM_BASE - 3) ? EW + 1 : NORM_BASE - 3;
   localparam int PAD  = RB_E + 3 - NORM_BASE;
   localparam int LW   = (EW + 1 + KM > 63) ? 63 : EW + 1 + KM;
   localparam int LWIDE = (RB_E + 3 > 64) ? RB_E + 3 : 64;
   localparam int AW   = 2*LW + 1;
   localparam int MW   = $clog2(DW + 1);
   localparam logic [LWIDE-1:0] LEN_SAT = LWIDE'(64'h7fff_ffff_ffff_ffff);
   localparam logic [AW-1:0]    AREA_MAX = AW'({1'b0, {(CW-1){1'b1}}});

   logic signed [CW-1:0] cin [4][3];
   logic adv, tail_v, busy_ff, beat_done, last_done, load_ok;
   kind_type kind_ff;

   assign cin[0] = '{req_lead_inner_x,  req_lead_inner_y,  req_lead_inner_z};
   assign cin[1] = '{req_lead_outer_x,  req_lead_outer_y,  req_lead_outer_z};
   assign cin[2] = '{req_trail_outer_x, req_trail_outer_y, req_trail_outer_z};
   assign cin[3] = '{req_trail_inner_x, req_trail_inner_y, req_trail_inner_z};

   // stage 1: differences, diagonals, edges, midpoint directions, control point
   logic                 v_ff   [5];
   logic signed [DW-1:0] g_ff   [6][3];
   logic signed [DW-1:0] g_in   [6][3];
   logic signed [CW+1:0] chd_ff [5][3];
   logic signed [CW+1:0] spd_ff [5][3];
   logic signed [CW-1:0] cpd_ff [5][3];
   logic signed [CW+1:0] ch_in  [3];
   logic signed [CW+1:0] sp_in  [3];
   logic signed [CW-1:0] cp_in  [3];

   always_comb begin
      logic signed [CW+3:0] t3, s;
      for (int k = 0; k < 3; k++) begin
         g_in[0][k] = DW'(cin[2][k]) - DW'(cin[0][k]);
         g_in[1][k] = DW'(cin[1][k]) - DW'(cin[3][k]);
         for (int i = 0; i < 4; i++) begin
            g_in[2+i][k] = DW'(cin[(i+1)%4][k]) - DW'(cin[i][k]);
         end
         ch_in[k] = (CW+2)'(cin[2][k]) + (CW+2)'(cin[3][k])
                  - (CW+2)'(cin[0][k]) - (CW+2)'(cin[1][k]);
         sp_in[k] = (CW+2)'(cin[1][k]) + (CW+2)'(cin[2][k])
                  - (CW+2)'(cin[0][k]) - (CW+2)'(cin[3][k]);
         t3 = (CW+4)'(cin[2][k]) + (CW+4)'(cin[3][k]);
         s  = (CW+4)'(cin[0][k]) + (CW+4)'(cin[1][k]) + t3 + t3 + t3 + (CW+4)'(4);
         cp_in[k] = s[CW+2:3];
      end
   end

   // stage 2: magnitudes and shrink amounts
   logic [DW-1:0] mag2_ff [6][3];
   logic          neg2_ff [6][3];
   logic [1:0]    k2_ff   [6];
   logic [DW-1:0] mag_in  [6][3];
   logic [1:0]    k_in    [6];

   always_comb begin
      logic [DW-1:0] orv;
      logic [MW-1:0] m;
      for (int v = 0; v < 6; v++) begin
         orv = '0;
         m   = '0;
         for (int k = 0; k < 3; k++) begin
            mag_in[v][k] = g_ff[v][k][DW-1] ? DW'(-g_ff[v][k]) : DW'(g_ff[v][k]);
            orv = orv | mag_in[v][k];
         end
         for (int b = 0; b < DW; b++) begin
            if (orv[b]) begin
               m = MW'(b + 1);
            end
         end
         k_in[v] = (int'(m) > MAX_BITS) ? 2'(int'(m) - MAX_BITS) : 2'd0;
      end
   end

   // stage 3: shrunk magnitudes
   logic [EW-1:0] sh3_ff  [6][3];
   logic          neg3_ff [6][3];
   logic [1:0]    ke_ff   [3][4];

   // stage 4: cross partial products, edge squares
   logic signed [PW-1:0]   pr4_ff [6];
   logic [2*EW-1:0]        sq4_ff [4][3];
   logic signed [EW:0]     sa [3];
   logic signed [EW:0]     sb [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sa[k] = neg3_ff[0][k] ? -$signed({1'b0, sh3_ff[0][k]}) : $signed({1'b0, sh3_ff[0][k]});
         sb[k] = neg3_ff[1][k] ? -$signed({1'b0, sh3_ff[1][k]}) : $signed({1'b0, sh3_ff[1][k]});
      end
   end

   // stage 5: cross product, edge sums of squares
   logic signed [XW-1:0] cr5_ff [3];
   logic [SW-1:0]        es5_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 5; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s < 5; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff      <= g_in;
         chd_ff[0] <= ch_in;
         spd_ff[0] <= sp_in;
         cpd_ff[0] <= cp_in;
         for (int s = 1; s < 5; s++) begin
            chd_ff[s] <= chd_ff[s-1];
            spd_ff[s] <= spd_ff[s-1];
            cpd_ff[s] <= cpd_ff[s-1];
         end
         for (int v = 0; v < 6; v++) begin
            k2_ff[v] <= k_in[v];
            for (int k = 0; k < 3; k++) begin
               mag2_ff[v][k] <= mag_in[v][k];
               neg2_ff[v][k] <= g_ff[v][k][DW-1];
               sh3_ff[v][k]  <= EW'(mag2_ff[v][k] >> k2_ff[v]);
               neg3_ff[v][k] <= neg2_ff[v][k];
            end
         end
         for (int i = 0; i < 4; i++) begin
            ke_ff[0][i] <= k2_ff[2+i];
            ke_ff[1][i] <= ke_ff[0][i];
            ke_ff[2][i] <= ke_ff[1][i];
            for (int k = 0; k < 3; k++) begin
               sq4_ff[i][k] <= (2*EW)'(sh3_ff[2+i][k]) * (2*EW)'(sh3_ff[2+i][k]);
            end
            es5_ff[i] <= SW'(sq4_ff[i][0]) + SW'(sq4_ff[i][1]) + SW'(sq4_ff[i][2]);
         end
         pr4_ff[0] <= PW'(sa[1]) * PW'(sb[2]);
         pr4_ff[1] <= PW'(sa[2]) * PW'(sb[1]);
         pr4_ff[2] <= PW'(sa[2]) * PW'(sb[0]);
         pr4_ff[3] <= PW'(sa[0]) * PW'(sb[2]);
         pr4_ff[4] <= PW'(sa[0]) * PW'(sb[1]);
         pr4_ff[5] <= PW'(sa[1]) * PW'(sb[0]);
         for (int j = 0; j < 3; j++) begin
            cr5_ff[j] <= XW'(pr4_ff[2*j]) - XW'(pr4_ff[2*j+1]);
         end
      end
   end

   // unit vectors
   logic signed [CW-1:0] u_nrm [3];
   logic signed [CW-1:0] u_chd [3];
   logic signed [CW-1:0] u_spn [3];

   qpg_norm #(.IW(XW), .CW(CW), .PAD(PAD)) u_norm_nrm (
      .clock (clock), .adv (adv), .vec_in (cr5_ff), .unit_out (u_nrm)
   );

   qpg_norm #(.IW(CW+2), .CW(CW), .PAD(PAD)) u_norm_chd (
      .clock (clock), .adv (adv), .vec_in (chd_ff[4]), .unit_out (u_chd)
   );

   qpg_norm #(.IW(CW+2), .CW(CW), .PAD(PAD)) u_norm_spn (
      .clock (clock), .adv (adv), .vec_in (spd_ff[4]), .unit_out (u_spn)
   );

   // edge lengths
   logic [RB_E-1:0] root_e [4];
   logic [1:0]      k_e    [4];

   for (genvar i = 0; i < 4; i++) begin : g_edge
      qpg_sqrt #(.VW(SW), .RB(RB_E), .TW(2)) u_sqrt (
         .clock    (clock),
         .adv      (adv),
         .rad_in   (es5_ff[i]),
         .tag_in   (ke_ff[2][i]),
         .root_out (root_e[i]),
         .tag_out  (k_e[i])
      );
   end

   logic                 vq_ff  [RB_E];
   logic signed [CW-1:0] cpq_ff [RB_E][3];
   logic                 ve_ff  [3];
   logic signed [CW-1:0] cpe_ff [3][3];
   logic [LW-1:0]        len_ff [4];
   logic [2*LW-1:0]      p_ff   [2];
   logic signed [CW-1:0] area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < RB_E; s++) begin
            vq_ff[s] <= 1'b0;
         end
         for (int s = 0; s < 3; s++) begin
            ve_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vq_ff[0] <= v_ff[4];
         for (int s = 1; s < RB_E; s++) begin
            vq_ff[s] <= vq_ff[s-1];
         end
         ve_ff[0] <= vq_ff[RB_E-1];
         ve_ff[1] <= ve_ff[0];
         ve_ff[2] <= ve_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      logic [LWIDE-1:0] wide;
      logic [AW-1:0]    asum;
      if (adv) begin
         cpq_ff[0] <= cpd_ff[4];
         for (int s = 1; s < RB_E; s++) begin
            cpq_ff[s] <= cpq_ff[s-1];
         end
         cpe_ff[0] <= cpq_ff[RB_E-1];
         cpe_ff[1] <= cpe_ff[0];
         cpe_ff[2] <= cpe_ff[1];
         for (int i = 0; i < 4; i++) begin
            wide = LWIDE'(root_e[i]) << k_e[i];
            if (wide > LEN_SAT) begin
               wide = LEN_SAT;
            end
            len_ff[i] <= LW'(wide);
         end
         p_ff[0] <= (2*LW)'(len_ff[0]) * (2*LW)'(len_ff[1]);
         p_ff[1] <= (2*LW)'(len_ff[2]) * (2*LW)'(len_ff[3]);
         asum = (AW'(p_ff[0]) + AW'(p_ff[1]) + (AW'(1) << FRAC_BITS)) >> AREA_SHIFT;
         area_ff <= (asum > AREA_MAX) ? CW'(AREA_MAX) : CW'(asum);
      end
   end

   // output buffer
   logic signed [CW-1:0] ob_ff [5][3];

   assign tail_v    = ve_ff[2];
   assign beat_done = busy_ff && !rsp_stall;
   assign last_done = beat_done && (kind_ff == KIND_AREA);
   assign load_ok   = !busy_ff || last_done;
   assign adv       = !tail_v || load_ok;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         kind_ff <= KIND_NORMAL;
      end else if (adv && tail_v) begin
         busy_ff <= 1'b1;
         kind_ff <= KIND_NORMAL;
      end else if (last_done) begin
         busy_ff <= 1'b0;
      end else if (beat_done) begin
         kind_ff <= kind_type'(kind_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tail_v) begin
         ob_ff[KIND_NORMAL] <= u_nrm;
         ob_ff[KIND_CHORD]  <= u_chd;
         ob_ff[KIND_SPAN]   <= u_spn;
         ob_ff[KIND_CTRL]   <= cpe_ff[2];
         ob_ff[KIND_AREA]   <= '{area_ff, '0, '0};
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_value_x       = ob_ff[kind_ff][0];
   assign rsp_value_y       = ob_ff[kind_ff][1];
   assign rsp_value_z       = ob_ff[kind_ff][2];
   assign rsp_last_of_panel = (kind_ff == KIND_AREA);

   a_last_on_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_panel == (rsp_result_kind == KIND_AREA)))
      else $error("last flag not on area result");

   a_area_yz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_AREA) |-> (rsp_value_y == '0 && rsp_value_z == '0))
      else $error("area result carries nonzero y or z");

   a_kind_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_result_kind != KIND_AREA) |=>
      (rsp_valid && rsp_result_kind == $past(rsp_result_kind) + 3'd1))
      else $error("result sequence skipped or repeated");

   a_empty_tail_free: assert property (@(posedge clock) disable iff (reset)
      !tail_v |-> !req_stall)
      else $error("input stalled with empty pipeline tail");

endmodule
